/* rtl/tx_record_structure_checker_top_macros.svh */
// assertion macros for the record checker
// clk and rst_n of the using module are taken as clock and reset
`ifndef TX_RECORD_STRUCTURE_CHECKER_TOP_MACROS_SVH
`define TX_RECORD_STRUCTURE_CHECKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TXRSC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TXRSC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TXRSC_CHECK(lbl, prop, msg)
`define TXRSC_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/txrsc_pkg.sv */
// shared types and constants for the transaction record checker
// no dependencies
`timescale 1ns / 1ps

package txrsc_pkg;

  localparam int DATA_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int OUT_DATA_W  = 8;
  localparam int CNT_W       = 16;
  localparam int ACC_W       = 64;
  localparam int IDX_W       = 4;
  localparam int SHAMT_W     = 6;
  localparam int CFG_IDX_W   = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] VARINT_MAX_IDX  = IDX_W'(9);
  localparam logic [ACC_W-1:0] VERSION_REQ     = ACC_W'(2);
  localparam logic [ACC_W-1:0] OUT_BLOB_COUNT  = ACC_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_EXP_IN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_OUT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    PH_VERSION   = 4'd0,
    PH_UNLOCK    = 4'd1,
    PH_NIN       = 4'd2,
    PH_IN_TAG    = 4'd3,
    PH_IN_AMT    = 4'd4,
    PH_RING_CNT  = 4'd5,
    PH_RING_ELEM = 4'd6,
    PH_IN_BLOB   = 4'd7,
    PH_NOUT      = 4'd8,
    PH_OUT_TAG   = 4'd9,
    PH_OUT_AMT   = 4'd10,
    PH_OUT_BLOB  = 4'd11,
    PH_OUT_TAG2  = 4'd12,
    PH_EXTRA     = 4'd13,
    PH_SIG       = 4'd14,
    PH_DONE      = 4'd15
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_VERSION  = 3'd1,
    ST_NIN      = 3'd2,
    ST_NOUT     = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_TRAIL    = 3'd5,
    ST_OVERLONG = 3'd6
  } status_t;

  // classified byte as it sits in the queue
  typedef struct packed {
    logic [6:0] payload;
    logic       cont;
    logic       fin;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] exp_in;
    logic [CNT_W-1:0] exp_out;
  } cfg_t;

endpackage

/* rtl/txrsc_front.sv */
// front end: accepts record bytes, splits them into varint payload and flags,
// and buffers them in a short queue; uses txrsc_pkg
`timescale 1ns / 1ps

module txrsc_front
  import txrsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // final_byte
  output logic              q_valid,
  input  logic              q_ready,
  output item_t             q_item
);

  item_t              queue_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  item_t              new_item;
  logic               push;
  logic               pop;

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = queue_mem_r[rd_ptr_r];

  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    new_item.payload = in_tdata[6:0];
    new_item.cont    = in_tdata[7];
    new_item.fin     = in_tlast;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* rtl/txrsc_back.sv */
// back end: record parser walking the layout one queued byte per cycle unless
// a last byte waits on the result register; uses txrsc_pkg and assertion macros
`timescale 1ns / 1ps
`include "tx_record_structure_checker_top_macros.svh"

module txrsc_back
  import txrsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  item_t                 q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status
);

  phase_t             phase_r, phase_nxt;
  status_t            err_r, err_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   in_total_r, in_total_nxt;
  logic [CNT_W-1:0]   out_total_r, out_total_nxt;
  logic [CNT_W-1:0]   loop_r, loop_nxt;
  logic [ACC_W-1:0]   ring_r, ring_nxt;
  logic [ACC_W-1:0]   blob_r, blob_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               pop;
  logic [SHAMT_W-1:0] shamt;
  logic [ACC_W-1:0]   shifted;

  // handshake side
  always_comb begin
    q_ready    = !q_item.fin || !out_valid_r || out_ready;
    pop        = q_valid && q_ready;
    out_valid  = out_valid_r;
    out_status = out_status_r;
  end

  // seven payload bits per varint byte, low group first
  assign shamt   = SHAMT_W'({2'b00, idx_r} * SHAMT_W'(7));
  assign shifted = {{(ACC_W-7){1'b0}}, q_item.payload} << shamt;

  always_comb begin : next_state
    logic [ACC_W-1:0] vint;
    logic [CNT_W:0]   loop_inc;
    phase_nxt      = phase_r;
    err_nxt        = err_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    in_total_nxt   = in_total_r;
    out_total_nxt  = out_total_r;
    loop_nxt       = loop_r;
    ring_nxt       = ring_r;
    blob_nxt       = blob_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    vint           = acc_r | shifted;
    loop_inc       = {1'b0, loop_r} + (CNT_W+1)'(1);

    if (pop) begin
      if (err_r == ST_OK) begin
        if (blob_r != '0) begin
          blob_nxt = blob_r - ACC_W'(1);
        end else begin
          case (phase_r)
            PH_IN_TAG:  phase_nxt = PH_IN_AMT;
            PH_OUT_TAG: phase_nxt = PH_OUT_AMT;
            PH_OUT_TAG2: begin
              loop_nxt  = loop_inc[CNT_W-1:0];
              phase_nxt = (loop_inc < {1'b0, out_total_r}) ? PH_OUT_TAG : PH_EXTRA;
            end
            PH_DONE:    err_nxt = ST_TRAIL;
            default: begin
              if (!q_item.cont) begin
                acc_nxt = '0;
                idx_nxt = '0;
                case (phase_r)
                  PH_VERSION: begin
                    if (vint != VERSION_REQ) begin
                      err_nxt = ST_VERSION;
                    end else begin
                      phase_nxt = PH_UNLOCK;
                    end
                  end
                  PH_UNLOCK: phase_nxt = PH_NIN;
                  PH_NIN: begin
                    if (vint != {{(ACC_W-CNT_W){1'b0}}, cfg.exp_in}) begin
                      err_nxt = ST_NIN;
                    end else begin
                      in_total_nxt = vint[CNT_W-1:0];
                      loop_nxt     = '0;
                      phase_nxt    = (vint != '0) ? PH_IN_TAG : PH_NOUT;
                    end
                  end
                  PH_IN_AMT: phase_nxt = PH_RING_CNT;
                  PH_RING_CNT: begin
                    ring_nxt  = vint;
                    phase_nxt = (vint != '0) ? PH_RING_ELEM : PH_IN_BLOB;
                  end
                  PH_RING_ELEM: begin
                    ring_nxt = ring_r - ACC_W'(1);
                    if (ring_r == ACC_W'(1)) begin
                      phase_nxt = PH_IN_BLOB;
                    end
                  end
                  PH_IN_BLOB: begin
                    blob_nxt  = vint;
                    loop_nxt  = loop_inc[CNT_W-1:0];
                    phase_nxt = (loop_inc < {1'b0, in_total_r}) ? PH_IN_TAG : PH_NOUT;
                  end
                  PH_NOUT: begin
                    if (vint != {{(ACC_W-CNT_W){1'b0}}, cfg.exp_out}) begin
                      err_nxt = ST_NOUT;
                    end else begin
                      out_total_nxt = vint[CNT_W-1:0];
                      loop_nxt      = '0;
                      phase_nxt     = (vint != '0) ? PH_OUT_TAG : PH_EXTRA;
                    end
                  end
                  PH_OUT_AMT: begin
                    ring_nxt  = OUT_BLOB_COUNT;
                    phase_nxt = PH_OUT_BLOB;
                  end
                  PH_OUT_BLOB: begin
                    blob_nxt = vint;
                    ring_nxt = ring_r - ACC_W'(1);
                    if (ring_r == ACC_W'(1)) begin
                      phase_nxt = PH_OUT_TAG2;
                    end
                  end
                  PH_EXTRA: begin
                    blob_nxt  = vint;
                    loop_nxt  = '0;
                    phase_nxt = (in_total_r != '0) ? PH_SIG : PH_DONE;
                  end
                  PH_SIG: begin
                    blob_nxt = vint;
                    loop_nxt = loop_inc[CNT_W-1:0];
                    if (loop_inc >= {1'b0, in_total_r}) begin
                      phase_nxt = PH_DONE;
                    end
                  end
                  default: ;
                endcase
              end else if (idx_r >= VARINT_MAX_IDX) begin
                acc_nxt = vint;
                err_nxt = ST_OVERLONG;
              end else begin
                acc_nxt = vint;
                idx_nxt = idx_r + IDX_W'(1);
              end
            end
          endcase
        end
      end

      if (q_item.fin) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = err_nxt;
        if (err_nxt == ST_OK &&
            (phase_nxt != PH_DONE || blob_nxt != '0 || idx_nxt != '0)) begin
          out_status_nxt = ST_TRUNC;
        end
        // fresh record after the last beat
        phase_nxt     = PH_VERSION;
        err_nxt       = ST_OK;
        acc_nxt       = '0;
        idx_nxt       = '0;
        in_total_nxt  = '0;
        out_total_nxt = '0;
        loop_nxt      = '0;
        ring_nxt      = '0;
        blob_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_VERSION;
      err_r        <= ST_OK;
      acc_r        <= '0;
      idx_r        <= '0;
      in_total_r   <= '0;
      out_total_r  <= '0;
      loop_r       <= '0;
      ring_r       <= '0;
      blob_r       <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      err_r        <= err_nxt;
      acc_r        <= acc_nxt;
      idx_r        <= idx_nxt;
      in_total_r   <= in_total_nxt;
      out_total_r  <= out_total_nxt;
      loop_r       <= loop_nxt;
      ring_r       <= ring_nxt;
      blob_r       <= blob_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  `TXRSC_CHECK(idx_in_range, idx_r <= VARINT_MAX_IDX, "varint byte index past limit")
  `TXRSC_CHECK_NEXT(final_gives_result, pop && q_item.fin, out_valid_r,
                    "final beat did not load a result")
  `TXRSC_CHECK_NEXT(final_clears_parse, pop && q_item.fin,
                    phase_r == PH_VERSION && blob_r == '0 && idx_r == '0 && err_r == ST_OK,
                    "parse state not cleared after final beat")
  `TXRSC_CHECK_NEXT(error_freezes_parse, pop && !q_item.fin && err_r != ST_OK,
                    $stable(phase_r) && $stable(err_r) && $stable(blob_r),
                    "parse state moved after an error was latched")

endmodule

/* rtl/tx_record_structure_checker_top.sv */
// Transaction record structure checker, top level.
// Bytes of a serialized record enter on the in_ stream, one byte per beat,
// with in_tlast on the last byte of the record. Varints are unsigned LEB128.
// On the last byte one status beat leaves on the out_ stream:
//   0 ok, 1 bad version, 2 input count, 3 output count, 4 truncated,
//   5 trailing bytes, 6 overlong varint.
// Other bytes produce nothing on the output.
// The cfg_ port writes the expected input count (index 0) and the expected
// output count (index 1); cfg_ready is always high. Write only while idle.
// Throughput: one byte per clock sustained, set by the parser in the back end,
// which retires one queued byte each cycle unless a last byte waits for the
// previous result to be taken. The last byte passes through the byte queue; the
// parser then loads its status into the result register, which drives out_tvalid.
// Reset (rst_n low, synchronous) empties the 4-entry byte queue, clears both
// count registers to 0 and puts the parser at the start of a record.
// When the receiver stalls, the result register holds; the parser keeps
// consuming ordinary bytes and waits only on a last byte, and in_tready drops
// once the queue is full.
// Uses txrsc_pkg, txrsc_front and txrsc_back.
`timescale 1ns / 1ps

module tx_record_structure_checker_top
  import txrsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,    // [7:0] data_byte
  input  logic                  in_tlast,    // final_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [2:0] status, [7:3] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  cfg_t                cfg_r, cfg_nxt;
  logic                q_valid;
  logic                q_ready;
  item_t               q_item;
  logic [STATUS_W-1:0] status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXP_IN:  cfg_nxt.exp_in  = cfg_data;
        CFG_EXP_OUT: cfg_nxt.exp_out = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  txrsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  txrsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status)
  );

  assign out_tdata = {{(OUT_DATA_W-STATUS_W){1'b0}}, status};

endmodule

/* test/tb_top.sv */
// self-checking testbench for tx_record_structure_checker_top
// directed table, then random records checked against an in-bench record parser
// depends on txrsc_pkg and the checker RTL
`timescale 1ns / 1ps

module tb_top
  import txrsc_pkg::*;
();

  typedef enum int {
    REC_GOOD, REC_BAD_VER, REC_BAD_NIN, REC_BAD_NOUT,
    REC_CUT, REC_TRAIL, REC_OVERLONG, REC_NOISE
  } rec_kind_t;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    status_t    st;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;    // [7:0] data_byte
  logic                  in_tlast = 1'b0;  // final_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [2:0] status, [7:3] zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CNT_W-1:0]      cfg_data = '0;

  tx_record_structure_checker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // parser mirror: register copies and per-record state
  logic [CNT_W-1:0] exp_in_reg = '0;
  logic [CNT_W-1:0] exp_out_reg = '0;
  phase_t           rec_phase;
  logic [63:0]      vi_acc;
  logic [3:0]       vi_idx;
  logic [63:0]      n_in;
  logic [63:0]      n_out;
  logic [63:0]      loop_i;
  logic [63:0]      ring_left;
  logic [63:0]      blob_left;
  status_t          rec_err;

  status_t     pending_status[$];
  logic [7:0]  rec_q[$];
  int          mismatch_cnt = 0;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 52;
  int          long_stall_req = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  dir_row_t    dir_rows [31];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic void clear_record();
    rec_phase = PH_VERSION;
    vi_acc    = '0;
    vi_idx    = '0;
    n_in      = '0;
    n_out     = '0;
    loop_i    = '0;
    ring_left = '0;
    blob_left = '0;
    rec_err   = ST_OK;
  endfunction

  function automatic void parse_record_byte(input logic [7:0] b, input logic fin,
                                            output logic has_res, output status_t res);
    logic [63:0] v;
    has_res = 1'b0;
    res = ST_OK;
    // once an error is latched the rest of the record is ignored
    if (rec_err == ST_OK) begin
      if (blob_left != 0) begin
        blob_left--;
      end else begin
        case (rec_phase)
          PH_IN_TAG:  rec_phase = PH_IN_AMT;
          PH_OUT_TAG: rec_phase = PH_OUT_AMT;
          PH_OUT_TAG2: begin
            loop_i++;
            rec_phase = (loop_i < n_out) ? PH_OUT_TAG : PH_EXTRA;
          end
          PH_DONE: rec_err = ST_TRAIL;
          default: begin
            vi_acc |= {57'd0, b[6:0]} << (7 * vi_idx);
            if (!b[7]) begin
              v = vi_acc;
              vi_acc = '0;
              vi_idx = '0;
              case (rec_phase)
                PH_VERSION: begin
                  if (v != VERSION_REQ) rec_err = ST_VERSION;
                  else rec_phase = PH_UNLOCK;
                end
                PH_UNLOCK: rec_phase = PH_NIN;
                PH_NIN: begin
                  if (v != {48'd0, exp_in_reg}) begin
                    rec_err = ST_NIN;
                  end else begin
                    n_in = v;
                    loop_i = '0;
                    rec_phase = (v != 0) ? PH_IN_TAG : PH_NOUT;
                  end
                end
                PH_IN_AMT: rec_phase = PH_RING_CNT;
                PH_RING_CNT: begin
                  ring_left = v;
                  rec_phase = (v != 0) ? PH_RING_ELEM : PH_IN_BLOB;
                end
                PH_RING_ELEM: begin
                  ring_left--;
                  if (ring_left == 0) rec_phase = PH_IN_BLOB;
                end
                PH_IN_BLOB: begin
                  blob_left = v;
                  loop_i++;
                  rec_phase = (loop_i < n_in) ? PH_IN_TAG : PH_NOUT;
                end
                PH_NOUT: begin
                  if (v != {48'd0, exp_out_reg}) begin
                    rec_err = ST_NOUT;
                  end else begin
                    n_out = v;
                    loop_i = '0;
                    rec_phase = (v != 0) ? PH_OUT_TAG : PH_EXTRA;
                  end
                end
                PH_OUT_AMT: begin
                  // ring_left counts the two blobs of an output
                  ring_left = OUT_BLOB_COUNT;
                  rec_phase = PH_OUT_BLOB;
                end
                PH_OUT_BLOB: begin
                  blob_left = v;
                  ring_left--;
                  if (ring_left == 0) rec_phase = PH_OUT_TAG2;
                end
                PH_EXTRA: begin
                  blob_left = v;
                  loop_i = '0;
                  rec_phase = (n_in != 0) ? PH_SIG : PH_DONE;
                end
                PH_SIG: begin
                  blob_left = v;
                  loop_i++;
                  if (loop_i >= n_in) rec_phase = PH_DONE;
                end
                default: ;
              endcase
            end else if (vi_idx >= VARINT_MAX_IDX) begin
              rec_err = ST_OVERLONG;
            end else begin
              vi_idx++;
            end
          end
        endcase
      end
    end
    if (fin) begin
      has_res = 1'b1;
      res = rec_err;
      if (res == ST_OK && (rec_phase != PH_DONE || blob_left != 0 || vi_idx != 0))
        res = ST_TRUNC;
      clear_record();
    end
  endfunction

  // record generation
  function automatic logic [63:0] rand_value();
    case ($urandom_range(3))
      0:       return 64'($urandom_range(0, 127));
      1:       return 64'($urandom_range(0, 16383));
      2:       return {$urandom, $urandom};
      default: return 64'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] miscount(input logic [CNT_W-1:0] want);
    case ($urandom_range(2))
      0:       return {48'd0, want} + 64'd1;
      1:       return {48'd0, want ^ (CNT_W'(1) << $urandom_range(CNT_W - 1))};
      default: return {$urandom, $urandom} | 64'h1_0000;  // high bits set
    endcase
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    rec_q = {rec_q, b};
  endfunction

  // leb128, now and then with redundant zero groups
  function automatic void emit_leb128(input logic [63:0] v);
    logic [63:0] rest = v;
    int pad = (v < 64'h1_0000_0000_0000 && $urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
    while (1) begin
      if (rest[63:7] == 0 && pad == 0) begin
        append_byte({1'b0, rest[6:0]});
        break;
      end
      append_byte({1'b1, rest[6:0]});
      if (rest[63:7] == 0) pad--;
      rest = rest >> 7;
    end
  endfunction

  function automatic void put_rand_blob();
    int len = ($urandom_range(9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
    emit_leb128(64'(len));
    repeat (len) append_byte(8'($urandom));
  endfunction

  function automatic void build_record(input rec_kind_t kind);
    logic [63:0] ver;
    logic [63:0] nin;
    logic [63:0] nout;
    int ring;
    int cut;
    rec_q.delete();
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
      return;
    end
    ver = VERSION_REQ;
    if (kind == REC_BAD_VER) begin
      ver = 64'($urandom_range(0, 40));
      if (ver == VERSION_REQ) ver = {$urandom, $urandom} | 64'h100;
    end
    emit_leb128(ver);
    if (kind == REC_OVERLONG) begin
      repeat (10) append_byte({1'b1, 7'($urandom)});
    end else if ($urandom_range(7) == 0) begin
      // full ten-byte varint, top payload bits fall off
      repeat (9) append_byte({1'b1, 7'($urandom)});
      append_byte({1'b0, 7'($urandom)});
    end else begin
      emit_leb128(rand_value());
    end
    nin = (kind == REC_BAD_NIN) ? miscount(exp_in_reg) : {48'd0, exp_in_reg};
    emit_leb128(nin);
    // huge counts: stop after the count, the record ends truncated
    if (nin > 3) return;
    for (int i = 0; i < nin; i++) begin
      append_byte(8'($urandom));
      emit_leb128(rand_value());
      ring = $urandom_range(0, 2);
      emit_leb128(64'(ring));
      repeat (ring) emit_leb128(rand_value());
      put_rand_blob();
    end
    nout = (kind == REC_BAD_NOUT) ? miscount(exp_out_reg) : {48'd0, exp_out_reg};
    emit_leb128(nout);
    if (nout > 3) return;
    for (int i = 0; i < nout; i++) begin
      append_byte(8'($urandom));
      emit_leb128(rand_value());
      put_rand_blob();
      put_rand_blob();
      append_byte(8'($urandom));
    end
    put_rand_blob();
    repeat (nin) put_rand_blob();
    if (kind == REC_CUT && rec_q.size() > 1) begin
      cut = $urandom_range(1, rec_q.size() - 1);
      while (rec_q.size() > cut) void'(rec_q.pop_back());
    end
    if (kind == REC_TRAIL) repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
  endfunction

  function automatic rec_kind_t pick_kind();
    int r = $urandom_range(99);
    if (r < 58) return REC_GOOD;
    if (r < 64) return REC_BAD_VER;
    if (r < 70) return REC_BAD_NIN;
    if (r < 76) return REC_BAD_NOUT;
    if (r < 84) return REC_CUT;
    if (r < 90) return REC_TRAIL;
    if (r < 95) return REC_OVERLONG;
    return REC_NOISE;
  endfunction

  // one byte beat; prediction is made at the accepting edge
  task automatic send_beat(input logic [7:0] b, input logic fin,
                           input logic typed, input status_t typed_st);
    logic has_res;
    status_t st;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_record_byte(b, fin, has_res, st);
    if (has_res) begin
      if (typed) st = typed_st;
      pending_status = {pending_status, st};
    end
  endtask

  task automatic program_counts(input logic [CNT_W-1:0] n_inputs,
                                input logic [CNT_W-1:0] n_outputs);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_EXP_IN;
    cfg_data  <= n_inputs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    exp_in_reg = n_inputs;
    cfg_index <= CFG_EXP_OUT;
    cfg_data  <= n_outputs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    exp_out_reg = n_outputs;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    int guard = 0;
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_status.size() != 0) begin
      report_mismatch($sformatf("%0d status beats never arrived", pending_status.size()));
      pending_status.delete();
    end
    // a few quiet cycles before the registers change
    repeat (10) @(posedge clk);
  endtask

  // receiver: random ready, with one long hold-off on request
  always @(posedge clk) begin
    if (stall_seen != long_stall_req) begin
      stall_seen <= long_stall_req;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status beat %0h with nothing pending", out_tdata));
      end else begin
        status_t want;
        want = pending_status.pop_front();
        if (out_tdata !== {5'd0, want})
          report_mismatch($sformatf("status got %0h want %0h", out_tdata, want));
      end
    end
  end

  initial begin
    int phase_bytes;
    int phase_recs;
    logic [CNT_W-1:0] cfg_in;
    logic [CNT_W-1:0] cfg_out;
    clear_record();
    dir_rows = '{
      // minimal good record, registers at reset
      '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b1, ST_OK},
      '{8'h03, 1'b1, 1'b1, ST_VERSION},
      '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b1, ST_NIN},
      '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b1, 1'b1, ST_NOUT},
      // last byte in the middle of a varint
      '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h80, 1'b1, 1'b1, ST_TRUNC},
      '{8'h02, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h7f, 1'b1, 1'b1, ST_TRAIL},
      // ten continuation bytes
      '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b0, 1'b0, ST_OK},
      '{8'hff, 1'b0, 1'b0, ST_OK}, '{8'hff, 1'b1, 1'b1, ST_OVERLONG}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].st);

    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      case (p)
        0:       begin cfg_in = 16'd0;     cfg_out = 16'd0;     end
        1:       begin cfg_in = 16'd1;     cfg_out = 16'd2;     end
        2:       begin cfg_in = 16'hffff;  cfg_out = 16'hffff;  end
        3:       begin cfg_in = 16'd2;     cfg_out = 16'd1;     end
        4:       begin cfg_in = 16'hffff;  cfg_out = 16'd0;     end
        default: begin
          cfg_in  = CNT_W'($urandom_range(0, 3));
          cfg_out = CNT_W'($urandom_range(0, 3));
        end
      endcase
      program_counts(cfg_in, cfg_out);
      send_idle_pct = (p < 2) ? 31 : (p < 4) ? 52 : 0;
      recv_idle_pct <= (p < 2) ? 52 : (p < 4) ? 31 : 0;
      phase_bytes = 0;
      phase_recs = 0;
      while (phase_bytes < 90 || phase_recs < 2) begin
        if (p == 1 && phase_recs == 1) begin
          // receiver holds off while one-byte records pile up behind it
          long_stall_req <= long_stall_req + 1;
          repeat (12) send_beat(8'h03, 1'b1, 1'b1, ST_VERSION);
        end
        build_record(pick_kind());
        for (int i = 0; i < rec_q.size(); i++)
          send_beat(rec_q[i], i == rec_q.size() - 1, 1'b0, ST_OK);
        phase_bytes += rec_q.size();
        phase_recs++;
      end
    end
    wait_for_results();

    if (mismatch_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
